// ===== sv/mtt_pkg.sv =====
// Package for the mirrored tree traversal core.
// Field widths, default node capacity and the controller/datapath command and status types.
// No dependencies.
package mtt_pkg;

    localparam int NODE_W        = 5;
    localparam int CHILD_W       = 6;
    localparam int REF_W         = 32;
    localparam int MAX_NODES_DEF = 32;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic root_set;
        logic no_root_emit;
        logic q_read;
        logic q_emit;
        logic q_right;
        logic q_left;
        logic in_init;
        logic i_push;
        logic i_rchild;
        logic i_pop;
        logic i_emit;
        logic i_lchild;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic in_last;
        logic scan_end;
        logic scan_ref;
        logic q_more;
        logic cur_ok;
        logic sp_zero;
        logic can_emit;
    } t_stat;

endpackage

// ===== sv/mtt_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module mtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mtt_ctrl.sv =====
// Sequencer of the mirrored tree traversal core: load, root scan, level-order and in-order walks.
// Depends on mtt_pkg (t_cmd, t_stat).
module mtt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mtt_pkg::t_stat i_stat,
    output mtt_pkg::t_cmd  o_cmd
);

    import mtt_pkg::*;

    typedef enum logic [10:0] {
        S_LOAD   = 11'b00000000001,
        S_SCAN   = 11'b00000000010,
        S_QRD    = 11'b00000000100,
        S_QEMIT  = 11'b00000001000,
        S_QRIGHT = 11'b00000010000,
        S_QLEFT  = 11'b00000100000,
        S_IPUSH  = 11'b00001000000,
        S_IRCH   = 11'b00010000000,
        S_IPOP   = 11'b00100000000,
        S_ILCH   = 11'b01000000000,
        S_FLUSH  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    if (i_stat.in_last) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.scan_end) begin
                    cmd.no_root_emit = 1'b1;
                    n_state          = S_FLUSH;
                end else if (!i_stat.scan_ref) begin
                    cmd.root_set = 1'b1;
                    n_state      = S_QRD;
                end else begin
                    cmd.scan_next = 1'b1;
                end
            end
            S_QRD: begin
                if (i_stat.q_more) begin
                    cmd.q_read = 1'b1;
                    n_state    = S_QEMIT;
                end else begin
                    cmd.in_init = 1'b1;
                    n_state     = S_IPUSH;
                end
            end
            S_QEMIT: begin
                if (i_stat.can_emit) begin
                    cmd.q_emit = 1'b1;
                    n_state    = S_QRIGHT;
                end
            end
            S_QRIGHT: begin
                cmd.q_right = 1'b1;
                n_state     = S_QLEFT;
            end
            S_QLEFT: begin
                cmd.q_left = 1'b1;
                n_state    = S_QRD;
            end
            S_IPUSH: begin
                if (i_stat.cur_ok) begin
                    cmd.i_push = 1'b1;
                    n_state    = S_IRCH;
                end else if (i_stat.sp_zero) begin
                    n_state = S_FLUSH;
                end else begin
                    cmd.i_pop = 1'b1;
                    n_state   = S_IPOP;
                end
            end
            S_IRCH: begin
                cmd.i_rchild = 1'b1;
                n_state      = S_IPUSH;
            end
            S_IPOP: begin
                if (i_stat.can_emit) begin
                    cmd.i_emit = 1'b1;
                    n_state    = S_ILCH;
                end
            end
            S_ILCH: begin
                cmd.i_lchild = 1'b1;
                n_state      = S_IPUSH;
            end
            S_FLUSH: begin
                if (i_stat.can_emit) begin
                    cmd.flush = 1'b1;
                    n_state   = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_LOAD);
    assign o_cmd      = cmd;

endmodule

// ===== sv/mtt_dpath.sv =====
// Datapath of the mirrored tree traversal core: child tables, walk queue and stack,
// reference and visited masks, pending result and output register.
// Depends on mtt_pkg and mtt_ram.
module mtt_dpath #(
    parameter int MAX_NODES = mtt_pkg::MAX_NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mtt_pkg::t_cmd                i_cmd,
    output mtt_pkg::t_stat               o_stat,
    input  logic [mtt_pkg::CHILD_W-1:0]  i_left_child,
    input  logic [mtt_pkg::CHILD_W-1:0]  i_right_child,
    input  logic                         i_last_node,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [mtt_pkg::NODE_W-1:0]   o_node_index,
    output logic                         o_walk_kind,
    output logic                         o_last_result,
    output logic                         o_no_root
);

    import mtt_pkg::*;

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    logic [REF_W-1:0]     r_ref, n_ref;
    logic [CW-1:0]        r_count, n_count;
    logic [CW-1:0]        r_scan, n_scan;
    logic [AW-1:0]        r_root, n_root;
    logic [MAX_NODES-1:0] r_seen, n_seen;
    logic [CW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_sp, n_sp;
    logic [AW-1:0]        r_cur, n_cur;
    logic                 r_cur_valid, n_cur_valid;
    logic                 r_p_valid, n_p_valid;
    logic [NODE_W-1:0]    r_p_idx, n_p_idx;
    logic                 r_p_kind, n_p_kind;
    logic                 r_p_noroot, n_p_noroot;
    logic                 r_out_valid, n_out_valid;
    logic [NODE_W-1:0]    r_out_idx, n_out_idx;
    logic                 r_out_kind, n_out_kind;
    logic                 r_out_last, n_out_last;
    logic                 r_out_noroot, n_out_noroot;

    logic                 t_we, t_re;
    logic [AW-1:0]        t_waddr, t_raddr;
    logic [CHILD_W-1:0]   tl_rdata, tr_rdata;
    logic                 q_we, q_re;
    logic [AW-1:0]        q_waddr, q_wdata, q_raddr, q_rdata;
    logic                 s_we, s_re;
    logic [AW-1:0]        s_waddr, s_raddr, s_rdata;

    logic                 room;
    logic                 tail_room;
    logic [AW-1:0]        r_addr, l_addr;
    logic                 r_take, l_take;
    logic                 can_emit;
    logic                 emit_en;
    logic [NODE_W-1:0]    emit_idx;
    logic                 emit_kind;
    logic                 emit_noroot;

    function automatic logic child_ok(logic [CHILD_W-1:0] raw, logic [CW-1:0] cnt);
        return !raw[CHILD_W-1] && ({1'b0, raw[NODE_W-1:0]} < (NODE_W + 1)'(cnt));
    endfunction

    mtt_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_NODES)) u_left_tab (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(i_left_child),
        .i_re(t_re), .i_raddr(t_raddr), .o_rdata(tl_rdata)
    );

    mtt_ram #(.WIDTH(CHILD_W), .DEPTH(MAX_NODES)) u_right_tab (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(i_right_child),
        .i_re(t_re), .i_raddr(t_raddr), .o_rdata(tr_rdata)
    );

    mtt_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_queue (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_re(q_re), .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    mtt_ram #(.WIDTH(AW), .DEPTH(MAX_NODES)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(r_cur),
        .i_re(s_re), .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    // child decode: negative or beyond the loaded count means none
    assign r_addr    = AW'(tr_rdata[NODE_W-1:0]);
    assign l_addr    = AW'(tl_rdata[NODE_W-1:0]);
    assign r_take    = child_ok(tr_rdata, r_count) && !r_seen[r_addr];
    assign l_take    = child_ok(tl_rdata, r_count) && !r_seen[l_addr];
    assign room      = (r_count < CW'(MAX_NODES));
    assign tail_room = (r_tail < CW'(MAX_NODES));
    assign can_emit  = !r_out_valid || i_out_ready;

    assign t_we    = i_cmd.load && room;
    assign t_waddr = AW'(r_count);
    assign t_re    = i_cmd.q_emit || i_cmd.i_push || i_cmd.i_emit;
    assign t_raddr = i_cmd.q_emit ? q_rdata : (i_cmd.i_push ? r_cur : s_rdata);

    assign q_we    = i_cmd.root_set
                     || (((i_cmd.q_right && r_take) || (i_cmd.q_left && l_take)) && tail_room);
    assign q_waddr = i_cmd.root_set ? '0 : AW'(r_tail);
    assign q_wdata = i_cmd.root_set ? AW'(r_scan) : (i_cmd.q_right ? r_addr : l_addr);
    assign q_re    = i_cmd.q_read;
    assign q_raddr = AW'(r_head);

    assign s_we    = i_cmd.i_push;
    assign s_waddr = AW'(r_sp);
    assign s_re    = i_cmd.i_pop;
    assign s_raddr = AW'(r_sp - CW'(1));

    always_comb begin
        emit_en     = 1'b0;
        emit_idx    = '0;
        emit_kind   = 1'b0;
        emit_noroot = 1'b0;
        if (i_cmd.no_root_emit) begin
            emit_en     = 1'b1;
            emit_noroot = 1'b1;
        end else if (i_cmd.q_emit) begin
            emit_en  = 1'b1;
            emit_idx = NODE_W'(q_rdata);
        end else if (i_cmd.i_emit) begin
            emit_en   = 1'b1;
            emit_idx  = NODE_W'(s_rdata);
            emit_kind = 1'b1;
        end
    end

    always_comb begin
        n_ref        = r_ref;
        n_count      = r_count;
        n_scan       = r_scan;
        n_root       = r_root;
        n_seen       = r_seen;
        n_head       = r_head;
        n_tail       = r_tail;
        n_sp         = r_sp;
        n_cur        = r_cur;
        n_cur_valid  = r_cur_valid;
        n_p_valid    = r_p_valid;
        n_p_idx      = r_p_idx;
        n_p_kind     = r_p_kind;
        n_p_noroot   = r_p_noroot;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_idx    = r_out_idx;
        n_out_kind   = r_out_kind;
        n_out_last   = r_out_last;
        n_out_noroot = r_out_noroot;

        if (i_cmd.load) begin
            n_scan = '0;
            if (room) begin
                if (!i_left_child[CHILD_W-1]) begin
                    n_ref[i_left_child[NODE_W-1:0]] = 1'b1;
                end
                if (!i_right_child[CHILD_W-1]) begin
                    n_ref[i_right_child[NODE_W-1:0]] = 1'b1;
                end
                n_count = r_count + CW'(1);
            end
        end
        if (i_cmd.scan_next) begin
            n_scan = r_scan + CW'(1);
        end
        if (i_cmd.root_set) begin
            n_root                = AW'(r_scan);
            n_seen                = '0;
            n_seen[AW'(r_scan)]   = 1'b1;
            n_head                = '0;
            n_tail                = CW'(1);
        end
        if (i_cmd.q_read) begin
            n_head = r_head + CW'(1);
        end
        if (i_cmd.q_right && r_take) begin
            n_seen[r_addr] = 1'b1;
            if (tail_room) begin
                n_tail = r_tail + CW'(1);
            end
        end
        if (i_cmd.q_left && l_take) begin
            n_seen[l_addr] = 1'b1;
            if (tail_room) begin
                n_tail = r_tail + CW'(1);
            end
        end
        if (i_cmd.in_init) begin
            n_seen         = '0;
            n_seen[r_root] = 1'b1;
            n_sp           = '0;
            n_cur          = r_root;
            n_cur_valid    = 1'b1;
        end
        if (i_cmd.i_push) begin
            n_sp = r_sp + CW'(1);
        end
        if (i_cmd.i_rchild) begin
            n_cur       = r_addr;
            n_cur_valid = r_take;
            if (r_take) begin
                n_seen[r_addr] = 1'b1;
            end
        end
        if (i_cmd.i_pop) begin
            n_sp = r_sp - CW'(1);
        end
        if (i_cmd.i_lchild) begin
            n_cur       = l_addr;
            n_cur_valid = l_take;
            if (l_take) begin
                n_seen[l_addr] = 1'b1;
            end
        end

        // one result held back so the final beat can carry the last flag
        if (emit_en) begin
            if (r_p_valid) begin
                n_out_valid  = 1'b1;
                n_out_idx    = r_p_idx;
                n_out_kind   = r_p_kind;
                n_out_last   = 1'b0;
                n_out_noroot = r_p_noroot;
            end
            n_p_valid  = 1'b1;
            n_p_idx    = emit_idx;
            n_p_kind   = emit_kind;
            n_p_noroot = emit_noroot;
        end
        if (i_cmd.flush) begin
            n_out_valid  = 1'b1;
            n_out_idx    = r_p_idx;
            n_out_kind   = r_p_kind;
            n_out_last   = 1'b1;
            n_out_noroot = r_p_noroot;
            n_p_valid    = 1'b0;
            n_ref        = '0;
            n_count      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= '0;
            r_count     <= '0;
            r_scan      <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_sp        <= '0;
            r_cur_valid <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ref       <= n_ref;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_sp        <= n_sp;
            r_cur_valid <= n_cur_valid;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root       <= n_root;
        r_seen       <= n_seen;
        r_cur        <= n_cur;
        r_p_idx      <= n_p_idx;
        r_p_kind     <= n_p_kind;
        r_p_noroot   <= n_p_noroot;
        r_out_idx    <= n_out_idx;
        r_out_kind   <= n_out_kind;
        r_out_last   <= n_out_last;
        r_out_noroot <= n_out_noroot;
    end

    assign o_stat.in_last  = i_last_node;
    assign o_stat.scan_end = (r_scan >= r_count);
    assign o_stat.scan_ref = r_ref[NODE_W'(r_scan)];
    assign o_stat.q_more   = (r_head < r_tail);
    assign o_stat.cur_ok   = r_cur_valid && (r_sp < CW'(MAX_NODES));
    assign o_stat.sp_zero  = (r_sp == '0);
    assign o_stat.can_emit = can_emit;

    assign o_out_valid   = r_out_valid;
    assign o_node_index  = r_out_idx;
    assign o_walk_kind   = r_out_kind;
    assign o_last_result = r_out_last;
    assign o_no_root     = r_out_noroot;

endmodule

// ===== sv/mirrored_tree_traversal_core.sv =====
// Node records are taken one beat per cycle, node 0 first, and cause no result until the
// record flagged last. The core then scans the indices in order for the root, the lowest
// unreferenced one, emits the level-order walk of the mirrored tree, each node taking a
// queue read, a table read, its right child and its left child, then the in-order walk,
// each node taking a stack push with table read and right child, then a stack pop, emit with
// table read and left child, each through a registered-read RAM. The final result carries
// the last flag; with no root a single flagged beat is given. Output stalls hold the walks.
// Records are not taken while a run is being walked out.
// Depends on mtt_pkg, mtt_ctrl, mtt_dpath and mtt_ram.
module mirrored_tree_traversal_core #(
    parameter int MAX_NODES = mtt_pkg::MAX_NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [mtt_pkg::CHILD_W-1:0]  i_left_child,
    input  logic [mtt_pkg::CHILD_W-1:0]  i_right_child,
    input  logic                         i_last_node,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mtt_pkg::NODE_W-1:0]   o_node_index,
    output logic                         o_walk_kind,
    output logic                         o_last_result,
    output logic                         o_no_root
);

    import mtt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mtt_dpath #(.MAX_NODES(MAX_NODES)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_left_child  (i_left_child),
        .i_right_child (i_right_child),
        .i_last_node   (i_last_node),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_node_index  (o_node_index),
        .o_walk_kind   (o_walk_kind),
        .o_last_result (o_last_result),
        .o_no_root     (o_no_root)
    );

endmodule
